FILE: sv/time_tagged_command_scheduler_unit_assert.svh
// Assertion macros for the time-tagged command scheduler.
// Used by files that take this header by include; needs clk and arst_n in scope.
`ifndef TIME_TAGGED_COMMAND_SCHEDULER_UNIT_ASSERT_SVH
`define TIME_TAGGED_COMMAND_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define TTS_ASSERT_NEXT(lbl, pre, post, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define TTS_ASSERT(lbl, cond, msg)
`define TTS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: sv/tts_pkg.sv
// Shared types and constants of the time-tagged command scheduler.
// No dependencies; used by the slot memory and the top level.
package tts_pkg;
	localparam int TableDepth = 32;
	localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int MaxResults = 32;
	localparam int CntW       = $clog2(MaxResults + 1);
	localparam int OccW       = 6;
	localparam int InDataW    = 80;
	localparam int OutDataW   = 88;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] time_value;
		logic [15:0] entry_id;
		logic [31:0] packet_tag;
	} slot_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] assigned_id;
		logic        dispatch_valid;
		logic [31:0] dispatched_tag;
		logic [31:0] dispatched_time;
	} result_t;
endpackage

FILE: sv/tts_slot_ram.sv
// Slot memory of the scheduler table: time, request id and packet tag per slot.
// One write port, one read port with registered read data; depends on tts_pkg.
module tts_slot_ram (
	input  logic                     clk,
	input  logic                     we,
	input  logic [tts_pkg::IdxW-1:0] waddr,
	input  tts_pkg::slot_t           wdata,
	input  logic [tts_pkg::IdxW-1:0] raddr,
	output tts_pkg::slot_t           rdata
);
	import tts_pkg::*;

	slot_t mem_q [TableDepth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: sv/time_tagged_command_scheduler_unit.sv
// Top level of the time-tagged command scheduler: request sequencer, valid bits, output register.
// Depends on tts_pkg, tts_slot_ram and the assertion macro header.
//
// Each request is handled alone while s_axis_tready is low. An insert walks the valid bits
// one slot per cycle until it finds a free slot or reaches the last one; a delete reads the slot
// memory one slot per cycle until the request id matches or the last slot has been read; a clear
// or a disabled tick needs no scan. A tick runs one full scan through the single memory read
// port and the one time comparator for every entry it dispatches, plus one final scan that
// finds nothing due, unless it stops after MaxResults dispatches. Each request ends by handing
// its last result to the output register, which holds it until taken; a stalled output makes
// the request wait in ST_EMIT, and a tick also waits in ST_TICK_DONE.
`include "time_tagged_command_scheduler_unit_assert.svh"
module time_tagged_command_scheduler_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,      // scheduler_enable
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [tts_pkg::InDataW-1:0]  s_axis_tdata,   // time_value, entry_id, packet_tag
	input  logic [1:0]                   s_axis_tuser,   // kind
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [tts_pkg::OutDataW-1:0] m_axis_tdata,   // status, assigned_id, dispatched_tag,
	                                                     // dispatched_time, occupied_count
	output logic                         m_axis_tuser,   // dispatch_valid
	output logic                         m_axis_tlast    // last_result
);
	import tts_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SCAN,
		ST_DEL_SCAN,
		ST_TICK_SCAN,
		ST_TICK_DONE,
		ST_EMIT
	} state_t;

	localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);

	state_t                state_q;
	logic                  enable_q;
	logic [TableDepth-1:0] valid_q;
	logic [OccW-1:0]       occ_q;
	logic [15:0]           next_id_q;
	kind_t                 kind_q;
	logic [31:0]           tval_q;
	logic [15:0]           rid_q;
	logic [31:0]           tag_q;
	logic [IdxW-1:0]       idx_q;
	logic                  issue_q;
	logic                  live_s1;
	logic [IdxW-1:0]       idx_s1;
	logic                  found_q;
	logic [IdxW-1:0]       best_idx_q;
	logic [31:0]           best_time_q;
	logic [31:0]           best_tag_q;
	logic [CntW-1:0]       cnt_q;
	result_t               pend_q;
	logic                  pend_valid_q;
	result_t               out_q;
	logic [OccW-1:0]       out_occ_q;
	logic                  out_last_q;
	logic                  out_valid_q;

	slot_t           rd_slot;
	slot_t           wr_slot;
	logic            ram_we;
	logic            out_free;
	logic            out_load;
	logic            last_issue;
	logic            s1_last;
	logic            cmp_le;
	logic            cmp_eq;
	logic            take;
	logic            id_hit;
	logic [15:0]     next_id_inc;
	logic [15:0]     next_id_nx;
	logic [CntW-1:0] cnt_nx;
	result_t         empty_res;

	tts_slot_ram u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (wr_slot),
		.raddr (idx_q),
		.rdata (rd_slot)
	);

	assign wr_slot     = '{time_value: tval_q, entry_id: next_id_q, packet_tag: tag_q};
	assign ram_we      = (state_q == ST_INS_SCAN) && !valid_q[idx_q];
	assign out_free    = !out_valid_q || m_axis_tready;
	assign out_load    = out_free && ((state_q == ST_EMIT) ||
		(state_q == ST_TICK_DONE && found_q && pend_valid_q));
	assign last_issue  = (idx_q == LastIdx);
	assign s1_last     = live_s1 && (idx_s1 == LastIdx);
	assign cmp_le      = (rd_slot.time_value <= best_time_q);
	assign cmp_eq      = (rd_slot.time_value == best_time_q);
	assign take        = live_s1 && valid_q[idx_s1] && (found_q ? (cmp_le && !cmp_eq) : cmp_le);
	assign id_hit      = live_s1 && valid_q[idx_s1] && (rd_slot.entry_id == rid_q);
	assign next_id_inc = next_id_q + 16'd1;
	assign next_id_nx  = (next_id_inc == 16'd0) ? 16'd1 : next_id_inc;
	assign cnt_nx      = cnt_q + CntW'(1);
	assign empty_res   = '{status: STATUS_OK, assigned_id: 16'd0, dispatch_valid: 1'b0,
		dispatched_tag: 32'd0, dispatched_time: 32'd0};

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_occ_q, out_q.dispatched_time, out_q.dispatched_tag,
		out_q.assigned_id, out_q.status};
	assign m_axis_tuser  = out_q.dispatch_valid;
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			enable_q     <= 1'b0;
			valid_q      <= '0;
			occ_q        <= '0;
			next_id_q    <= 16'd1;
			kind_q       <= KIND_INSERT;
			tval_q       <= '0;
			rid_q        <= '0;
			tag_q        <= '0;
			idx_q        <= '0;
			issue_q      <= 1'b0;
			live_s1      <= 1'b0;
			idx_s1       <= '0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_time_q  <= '0;
			best_tag_q   <= '0;
			cnt_q        <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			out_q        <= '0;
			out_occ_q    <= '0;
			out_last_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DEL_SCAN || state_q == ST_TICK_SCAN) begin
				if (issue_q) begin
					live_s1 <= 1'b1;
					idx_s1  <= idx_q;
					if (last_issue) begin
						issue_q <= 1'b0;
					end else begin
						idx_q <= idx_q + IdxW'(1);
					end
				end else begin
					live_s1 <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						kind_q       <= kind_t'(s_axis_tuser);
						tval_q       <= s_axis_tdata[31:0];
						rid_q        <= s_axis_tdata[47:32];
						tag_q        <= s_axis_tdata[79:48];
						idx_q        <= '0;
						issue_q      <= 1'b1;
						live_s1      <= 1'b0;
						found_q      <= 1'b0;
						best_time_q  <= s_axis_tdata[31:0];
						cnt_q        <= '0;
						pend_valid_q <= 1'b0;
						unique case (kind_t'(s_axis_tuser))
							KIND_INSERT: state_q <= ST_INS_SCAN;
							KIND_DELETE: state_q <= ST_DEL_SCAN;
							KIND_CLEAR: begin
								valid_q <= '0;
								occ_q   <= '0;
								pend_q  <= empty_res;
								state_q <= ST_EMIT;
							end
							KIND_TICK: begin
								if (enable_q) begin
									state_q <= ST_TICK_SCAN;
								end else begin
									pend_q  <= empty_res;
									state_q <= ST_EMIT;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_INS_SCAN: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						occ_q          <= occ_q + OccW'(1);
						next_id_q      <= next_id_nx;
						pend_q         <= '{status: STATUS_OK, assigned_id: next_id_q,
							dispatch_valid: 1'b0, dispatched_tag: 32'd0, dispatched_time: 32'd0};
						state_q        <= ST_EMIT;
					end else if (last_issue) begin
						pend_q  <= '{status: STATUS_FULL, assigned_id: 16'd0,
							dispatch_valid: 1'b0, dispatched_tag: 32'd0, dispatched_time: 32'd0};
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + IdxW'(1);
					end
				end
				ST_DEL_SCAN: begin
					if (id_hit) begin
						valid_q[idx_s1] <= 1'b0;
						occ_q           <= occ_q - OccW'(1);
						pend_q          <= empty_res;
						state_q         <= ST_EMIT;
					end else if (s1_last) begin
						pend_q  <= '{status: STATUS_NOT_FOUND, assigned_id: 16'd0,
							dispatch_valid: 1'b0, dispatched_tag: 32'd0, dispatched_time: 32'd0};
						state_q <= ST_EMIT;
					end
				end
				ST_TICK_SCAN: begin
					if (take) begin
						found_q     <= 1'b1;
						best_idx_q  <= idx_s1;
						best_time_q <= rd_slot.time_value;
						best_tag_q  <= rd_slot.packet_tag;
					end
					if (s1_last) begin
						state_q <= ST_TICK_DONE;
					end
				end
				ST_TICK_DONE: begin
					if (!found_q) begin
						if (!pend_valid_q) begin
							pend_q <= empty_res;
						end
						state_q <= ST_EMIT;
					end else if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							out_q      <= pend_q;
							out_occ_q  <= occ_q;
							out_last_q <= 1'b0;
						end
						pend_q <= '{status: STATUS_OK, assigned_id: 16'd0, dispatch_valid: 1'b1,
							dispatched_tag: best_tag_q, dispatched_time: best_time_q};
						pend_valid_q        <= 1'b1;
						valid_q[best_idx_q] <= 1'b0;
						occ_q               <= occ_q - OccW'(1);
						cnt_q               <= cnt_nx;
						if (cnt_nx == CntW'(MaxResults)) begin
							state_q <= ST_EMIT;
						end else begin
							idx_q       <= '0;
							issue_q     <= 1'b1;
							live_s1     <= 1'b0;
							found_q     <= 1'b0;
							best_time_q <= tval_q;
							state_q     <= ST_TICK_SCAN;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q        <= pend_q;
						out_occ_q    <= occ_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TTS_ASSERT(a_occ_matches_valid, occ_q == OccW'($countones(valid_q)), "occupied count drift")
	`TTS_ASSERT(a_next_id_nonzero, next_id_q != 16'd0, "next request id is zero")
	`TTS_ASSERT(a_cnt_bounded, cnt_q <= CntW'(MaxResults), "dispatch count over limit")
	`TTS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"request accepted while busy")
	`TTS_ASSERT_NEXT(a_insert_kind_scan, state_q == ST_INS_SCAN, kind_q == KIND_INSERT,
		"insert scan without insert request")
endmodule
